@@ rtl/core/ipafc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipafc_pkg: shared types and constants of the address format checker
// Character codes, token format between front and back, result codes.
// ----------------------------------------------------------------------------
package ipafc_pkg;

  // character codes
  localparam logic [7:0] CHAR_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CHAR_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UF    = 8'h46;  // 'F'
  localparam logic [7:0] CHAR_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LF    = 8'h66;  // 'f'

  // group and separator limits
  localparam logic [9:0] V4_MAX_VALUE  = 10'd255;
  localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
  localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
  localparam logic [2:0] LEN_SAT       = 3'd5;
  localparam logic [2:0] DOT_SAT       = 3'd4;
  localparam logic [3:0] COLON_SAT     = 4'd8;
  localparam logic [2:0] V4_DOTS       = 3'd3;
  localparam logic [3:0] V6_COLONS     = 4'd7;

  // depth of the token queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_DOT,
    KIND_COLON,
    KIND_DIGIT,
    KIND_HEX,
    KIND_OTHER
  } char_kind_t;

  typedef enum logic [1:0] {
    CLASS_NONE = 2'd0,
    CLASS_V4   = 2'd1,
    CLASS_V6   = 2'd2
  } addr_class_t;

  // one classified character
  typedef struct packed {
    char_kind_t  kind;
    logic [3:0]  digit;    // decimal value, valid for KIND_DIGIT
    logic        is_zero;  // character is '0'
    logic        last;
  } token_t;

  // back end status toward the top level
  typedef struct packed {
    logic consume;       // token taken from the queue this cycle
    logic consume_last;  // the taken token ends a string
  } back_stat_t;

endpackage : ipafc_pkg
`default_nettype wire

@@ rtl/core/ipafc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipafc_if: request channels of the address format checker
// Character input channel and classification result channel.
// ----------------------------------------------------------------------------
interface ipafc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface : ipafc_in_if

interface ipafc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] address_class;

  modport source (output valid, output address_class, input ready);
  modport sink   (input valid, input address_class, output ready);
endinterface : ipafc_out_if
`default_nettype wire

@@ rtl/core/ip_address_format_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ip_address_format_checker: IPv4 / IPv6 address string classifier
// Takes an address string one character per request and reports IPv4,
// IPv6 or neither after the character flagged as last.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                      meaning
//  in_ch     in   character[7:0], last         one character, last ends string
//  out_ch    out  address_class[1:0]           0 neither, 1 IPv4, 2 IPv6
//
//  One character per cycle while in_ch.ready is high. The classifier passes
//  each character through a two-entry token queue into the checker; a result
//  is registered in the output register after its last character has been
//  written into the queue and taken by the checker.
//  Only a final character waiting on a full output register stalls the
//  checker; the queue then fills and in_ch.ready drops.
//  Reset (rst_n low, synchronous) empties the queue and the output register
//  and starts a new string.
//
module ip_address_format_checker
  import ipafc_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  ipafc_in_if.sink    in_ch,
  ipafc_out_if.source out_ch
);

  // front to queue
  logic       push;
  token_t     push_tok;
  logic       push_ready;

  // queue to back
  logic       q_valid;
  token_t     q_tok;
  logic       q_pop;

  back_stat_t stat;

  // classify characters, hold off the source when the queue is full
  ipafc_front u_front (
    .in_ch      (in_ch),
    .push       (push),
    .push_tok   (push_tok),
    .push_ready (push_ready)
  );

  // buffer tokens while the checker stalls on a final character; the source is blocked only once the queue is full
  ipafc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tok   (push_tok),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_tok    (q_tok),
    .pop        (q_pop)
  );

  // advance string state and register the verdict
  ipafc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_valid),
    .tok       (q_tok),
    .tok_pop   (q_pop),
    .out_ch    (out_ch),
    .stat      (stat)
  );

  // a full queue must have something to drain
  a_full_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !push_ready |-> q_valid)
    else $error("token queue full but reports empty");

  // the checker stalls only on a final character blocked by the output
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !stat.consume) |-> (q_tok.last && out_ch.valid && !out_ch.ready))
    else $error("checker stalled without a blocked result");

  // a finished string produces a result in the next cycle
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    stat.consume_last |=> out_ch.valid)
    else $error("result missing after final character");

  // a taken result is not shown again unless a new string finished
  a_no_repeat : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !stat.consume_last) |=> !out_ch.valid)
    else $error("result repeated");

endmodule : ip_address_format_checker
`default_nettype wire

@@ rtl/core/ipafc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipafc_front: character classifier
// Accept characters and turn each into a token for the queue.
// ----------------------------------------------------------------------------
module ipafc_front
  import ipafc_pkg::*;
(
  ipafc_in_if.sink in_ch,
  output logic     push,
  output token_t   push_tok,
  input  logic     push_ready
);

  logic [7:0] c;
  logic       is_digit;
  logic       is_hex;

  assign c        = in_ch.character;
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_hex   = ((c >= CHAR_UA) && (c <= CHAR_UF)) || ((c >= CHAR_LA) && (c <= CHAR_LF));

  assign in_ch.ready = push_ready;
  assign push        = in_ch.valid && push_ready;

  always_comb begin
    push_tok.digit   = c[3:0];
    push_tok.is_zero = (c == CHAR_ZERO);
    push_tok.last    = in_ch.last;
    if (c == CHAR_DOT) begin
      push_tok.kind = KIND_DOT;
    end else if (c == CHAR_COLON) begin
      push_tok.kind = KIND_COLON;
    end else if (is_digit) begin
      push_tok.kind = KIND_DIGIT;
    end else if (is_hex) begin
      push_tok.kind = KIND_HEX;
    end else begin
      push_tok.kind = KIND_OTHER;
    end
  end

endmodule : ipafc_front
`default_nettype wire

@@ rtl/core/ipafc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipafc_queue: short token queue
// Decouple the classifier from the checker so each side stalls on its own.
// ----------------------------------------------------------------------------
module ipafc_queue
  import ipafc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t push_tok,
  output logic   push_ready,
  output logic   pop_valid,
  output token_t pop_tok,
  input  logic   pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

  token_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_tok    = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule : ipafc_queue
`default_nettype wire

@@ rtl/core/ipafc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipafc_back: address format checker
// Track separators and groups per token; register the verdict on the last one.
// ----------------------------------------------------------------------------
module ipafc_back
  import ipafc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         tok_valid,
  input  token_t       tok,
  output logic         tok_pop,
  ipafc_out_if.source  out_ch,
  output back_stat_t   stat
);

  logic        v4_r,    v4_nxt;
  logic        v6_r,    v6_nxt;
  logic [2:0]  dots_r,  dots_nxt;
  logic [3:0]  cols_r,  cols_nxt;
  logic [2:0]  len_r,   len_nxt;
  logic [9:0]  dec_r,   dec_nxt;
  logic        sz_r,    sz_nxt;
  logic        out_valid_r, out_valid_nxt;
  addr_class_t class_r, class_nxt;
  addr_class_t verdict;
  logic [13:0] dec_grow;
  logic        consume;

  function automatic logic v4_group_ok(input logic [2:0] len, input logic [9:0] dec,
                                       input logic sz);
    logic ok;
    ok = (len != 3'd0) && (len <= V4_MAX_DIGITS) && !((len > 3'd1) && sz)
         && (dec <= V4_MAX_VALUE);
    return ok;
  endfunction

  function automatic logic v6_group_ok(input logic [2:0] len);
    return (len != 3'd0) && (len <= V6_MAX_DIGITS);
  endfunction

  // take a token unless it ends a string and the result register is blocked
  assign consume = tok_valid && (!tok.last || !out_valid_r || out_ch.ready);
  assign tok_pop = consume;
  assign stat    = '{consume: consume, consume_last: consume && tok.last};

  assign dec_grow = 14'(dec_r) * 14'd10 + 14'(tok.digit);

  always_comb begin
    v4_nxt   = v4_r;
    v6_nxt   = v6_r;
    dots_nxt = dots_r;
    cols_nxt = cols_r;
    len_nxt  = len_r;
    dec_nxt  = dec_r;
    sz_nxt   = sz_r;
    case (tok.kind)
      KIND_DOT: begin
        if (!v4_group_ok(len_r, dec_r, sz_r)) v4_nxt = 1'b0;
        v6_nxt = 1'b0;
        if (dots_r < DOT_SAT) dots_nxt = dots_r + 1'b1;
        len_nxt = '0;
        dec_nxt = '0;
        sz_nxt  = 1'b0;
      end
      KIND_COLON: begin
        if (!v6_group_ok(len_r)) v6_nxt = 1'b0;
        v4_nxt = 1'b0;
        if (cols_r < COLON_SAT) cols_nxt = cols_r + 1'b1;
        len_nxt = '0;
        dec_nxt = '0;
        sz_nxt  = 1'b0;
      end
      KIND_DIGIT, KIND_HEX: begin
        if (tok.kind == KIND_HEX) v4_nxt = 1'b0;
        if (len_r == 3'd0) sz_nxt = tok.is_zero;
        if ((tok.kind == KIND_DIGIT) && (len_r < V4_MAX_DIGITS)) dec_nxt = dec_grow[9:0];
        if (len_r < LEN_SAT) len_nxt = len_r + 1'b1;
      end
      default: begin
        v4_nxt = 1'b0;
        v6_nxt = 1'b0;
      end
    endcase
  end

  // verdict on the state after this token
  always_comb begin
    if (v4_nxt && (dots_nxt == V4_DOTS) && v4_group_ok(len_nxt, dec_nxt, sz_nxt)) begin
      verdict = CLASS_V4;
    end else if (v6_nxt && (cols_nxt == V6_COLONS) && v6_group_ok(len_nxt)) begin
      verdict = CLASS_V6;
    end else begin
      verdict = CLASS_NONE;
    end
  end

  always_comb begin
    class_nxt     = class_r;
    out_valid_nxt = out_valid_r;
    if (consume && tok.last) begin
      out_valid_nxt = 1'b1;
      class_nxt     = verdict;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b1;
      v6_r        <= 1'b1;
      dots_r      <= '0;
      cols_r      <= '0;
      len_r       <= '0;
      dec_r       <= '0;
      sz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (consume && tok.last) begin
        v4_r   <= 1'b1;
        v6_r   <= 1'b1;
        dots_r <= '0;
        cols_r <= '0;
        len_r  <= '0;
        dec_r  <= '0;
        sz_r   <= 1'b0;
      end else if (consume) begin
        v4_r   <= v4_nxt;
        v6_r   <= v6_nxt;
        dots_r <= dots_nxt;
        cols_r <= cols_nxt;
        len_r  <= len_nxt;
        dec_r  <= dec_nxt;
        sz_r   <= sz_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    class_r <= class_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.address_class = class_r;

endmodule : ipafc_back
`default_nettype wire
